/* sv/tkw_pkg.sv */
// Shared types and constants for the top-k worst score tracker.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package tkw_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // Keep-count register
  localparam int         KEEP_BITS  = 5;
  localparam logic [4:0] KEEP_RESET = 5'd16;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic insert;
    logic rd_start;
    logic emit;
    logic emit_empty;
  } tkw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic held_empty;
    logic rd_last;
  } tkw_sts_t;

endpackage

`default_nettype wire

/* sv/tkw_in_if.sv */
// Input channel of the tracker: valid/ready handshake carrying one item word.
// No dependencies.
`default_nettype none

interface tkw_in_if #(
  parameter int SCORE_BITS = 32,
  parameter int INDEX_BITS = 20
) ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [SCORE_BITS-1:0] score;
  logic [INDEX_BITS-1:0] entry_index;

  modport source (output valid, kind, score, entry_index, input ready);
  modport sink   (input valid, kind, score, entry_index, output ready);
endinterface

`default_nettype wire

/* sv/tkw_out_if.sv */
// Result channel of the tracker: valid/ready handshake carrying one result word.
// No dependencies.
`default_nettype none

interface tkw_out_if #(
  parameter int SCORE_BITS = 32,
  parameter int INDEX_BITS = 20
) ();
  logic                  valid;
  logic                  ready;
  logic [SCORE_BITS-1:0] out_score;
  logic [INDEX_BITS-1:0] out_index;
  logic                  is_empty;
  logic                  last;

  modport source (output valid, out_score, out_index, is_empty, last, input ready);
  modport sink   (input valid, out_score, out_index, is_empty, last, output ready);
endinterface

`default_nettype wire

/* sv/top_k_worst_score_tracker.sv */
// Top level of the top-k worst score tracker: controller plus datapath.
// Depends on tkw_pkg, tkw_in_if, tkw_out_if, tkw_ctrl and tkw_dp.
`default_nettype none

// Keeps up to min(keep_count, MAX_KEEP) (score, index) pairs sorted by score,
// then by index, both descending. Each input word carries a kind: clear empties
// the list, insert places one pair at its sorted position (every slot is
// compared in parallel and the tail shifts down by one slot), read streams the
// held pairs out highest first, with last set on the final word. Reading an
// empty list gives one word with is_empty and last set and zero score and
// index. Clear, insert and unused kinds leave input ready high, so such words
// can arrive back to back. A read holds input ready low for as long as it runs:
// it sends one result word per held entry (one word for an empty list), and
// the sink can stall it, since the single result register paces the read
// pointer. Input is taken again as soon as the last result word is in the
// result register. Indices are not deduplicated. Lowering keep_count leaves
// held entries in place until the next insert, which trims the list. Write
// keep_count only while the block is idle.
module top_k_worst_score_tracker
  import tkw_pkg::*;
#(
  parameter int MAX_KEEP   = 16,
  parameter int INDEX_BITS = 20,
  parameter int SCORE_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 keep_count_we_i,
  input  wire logic [KEEP_BITS-1:0] keep_count_i,
  tkw_in_if.sink                    in_i,
  tkw_out_if.source                 out_o
);

  tkw_cmd_t cmd;
  tkw_sts_t sts;

  // Handshake and sequencing
  tkw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Sorted list, keep-count register and result word
  tkw_dp #(
    .MAX_KEEP   (MAX_KEEP),
    .INDEX_BITS (INDEX_BITS),
    .SCORE_BITS (SCORE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .keep_count_we_i (keep_count_we_i),
    .keep_count_i    (keep_count_i),
    .score_i         (in_i.score),
    .entry_index_i   (in_i.entry_index),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_score_o     (out_o.out_score),
    .out_index_o     (out_o.out_index),
    .is_empty_o      (out_o.is_empty),
    .last_o          (out_o.last)
  );

endmodule

`default_nettype wire

/* sv/tkw_ctrl.sv */
// Controller of the tracker: input acceptance, read-out sequencing, result valid.
// Depends on tkw_pkg.
`default_nettype none

module tkw_ctrl
  import tkw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] in_kind_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire tkw_sts_t   sts_i,
  output tkw_cmd_t        cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_kind_i)
            KIND_CLEAR:  cmd_o.clear  = 1'b1;
            KIND_INSERT: cmd_o.insert = 1'b1;
            KIND_READ: begin
              cmd_o.rd_start = 1'b1;
              state_d        = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (slot_free) begin
          if (sts_i.held_empty) begin
            cmd_o.emit_empty = 1'b1;
            state_d          = S_IDLE;
          end else begin
            cmd_o.emit = 1'b1;
            if (sts_i.rd_last) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.emit || cmd_o.emit_empty) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* sv/tkw_dp.sv */
// Datapath of the tracker: sorted slot registers, parallel insert, read pointer,
// keep-count register and result register. Depends on tkw_pkg.
`default_nettype none

module tkw_dp
  import tkw_pkg::*;
#(
  parameter int MAX_KEEP   = 16,
  parameter int INDEX_BITS = 20,
  parameter int SCORE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  keep_count_we_i,
  input  wire logic [KEEP_BITS-1:0]  keep_count_i,
  input  wire logic [SCORE_BITS-1:0] score_i,
  input  wire logic [INDEX_BITS-1:0] entry_index_i,
  input  wire tkw_cmd_t              cmd_i,
  output tkw_sts_t                   sts_o,
  output logic [SCORE_BITS-1:0]      out_score_o,
  output logic [INDEX_BITS-1:0]      out_index_o,
  output logic                       is_empty_o,
  output logic                       last_o
);

  localparam int CNT_W = $clog2(MAX_KEEP + 1);
  localparam int PTR_W = $clog2(MAX_KEEP);
  localparam int LIM_W = (CNT_W > KEEP_BITS) ? CNT_W : KEEP_BITS;

  logic [KEEP_BITS-1:0]  keep_q;
  logic [CNT_W-1:0]      held_q, held_d;
  logic [PTR_W-1:0]      rd_ptr_q;
  logic [SCORE_BITS-1:0] slot_score_q [MAX_KEEP];
  logic [INDEX_BITS-1:0] slot_index_q [MAX_KEEP];

  logic [LIM_W-1:0]      keep_ext, max_ext, lim_wide;
  logic [CNT_W-1:0]      limit, n_used;
  logic [MAX_KEEP-1:0]   at_or_after;   // slot lies at or after the insert position
  logic [MAX_KEEP-1:0]   below_limit;
  logic                  ins_ok;

  logic [SCORE_BITS-1:0] out_score_q;
  logic [INDEX_BITS-1:0] out_index_q;
  logic                  is_empty_q, last_q;

  // Effective limit: min(keep_count, MAX_KEEP)
  assign keep_ext = LIM_W'(keep_q);
  assign max_ext  = LIM_W'(MAX_KEEP);
  assign lim_wide = (keep_ext < max_ext) ? keep_ext : max_ext;
  assign limit    = CNT_W'(lim_wide);
  assign n_used   = (held_q < limit) ? held_q : limit;

  for (genvar j = 0; j < MAX_KEEP; j++) begin : g_cmp
    logic above;
    assign above = (score_i > slot_score_q[j]) ||
                   ((score_i == slot_score_q[j]) && (entry_index_i > slot_index_q[j]));
    assign at_or_after[j] = (CNT_W'(j) >= n_used) || above;
    assign below_limit[j] = (CNT_W'(j) < limit);
  end

  assign ins_ok = |(at_or_after & below_limit);

  // Slots: drop the new pair at its place, shift the tail down by one
  for (genvar j = 0; j < MAX_KEEP; j++) begin : g_slot
    logic take_new, take_prev;
    if (j == 0) begin : g_head
      assign take_new  = at_or_after[0];
      assign take_prev = 1'b0;
    end else begin : g_tail
      assign take_new  = at_or_after[j] && !at_or_after[j-1];
      assign take_prev = at_or_after[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.insert && ins_ok) begin
        if (take_new) begin
          slot_score_q[j] <= score_i;
          slot_index_q[j] <= entry_index_i;
        end else if (take_prev) begin
          if (j > 0) begin
            slot_score_q[j] <= slot_score_q[(j > 0) ? j - 1 : 0];
            slot_index_q[j] <= slot_index_q[(j > 0) ? j - 1 : 0];
          end
        end
      end
    end
  end

  always_comb begin
    held_d = held_q;
    if (cmd_i.clear) begin
      held_d = '0;
    end else if (cmd_i.insert) begin
      if (!ins_ok) begin
        held_d = n_used;
      end else if (n_used < limit) begin
        held_d = n_used + CNT_W'(1);
      end else begin
        held_d = limit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q   <= KEEP_RESET;
      held_q   <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (keep_count_we_i) begin
        keep_q <= keep_count_i;
      end
      held_q <= held_d;
      if (cmd_i.rd_start) begin
        rd_ptr_q <= '0;
      end else if (cmd_i.emit) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  assign sts_o.held_empty = (held_q == '0);
  assign sts_o.rd_last    = (CNT_W'(rd_ptr_q) == (held_q - CNT_W'(1)));

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_score_q <= slot_score_q[rd_ptr_q];
      out_index_q <= slot_index_q[rd_ptr_q];
      is_empty_q  <= 1'b0;
      last_q      <= sts_o.rd_last;
    end else if (cmd_i.emit_empty) begin
      out_score_q <= '0;
      out_index_q <= '0;
      is_empty_q  <= 1'b1;
      last_q      <= 1'b1;
    end
  end

  assign out_score_o = out_score_q;
  assign out_index_o = out_index_q;
  assign is_empty_o  = is_empty_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire
